>>> hw/rtl/lapic_pkg.sv
package lapic_pkg;

    // Width of the initial and current count registers (8 to 32)
    localparam int unsigned CountWidth = 32;

    // Item kinds
    localparam logic [1:0] KindRead  = 2'd0;
    localparam logic [1:0] KindWrite = 2'd1;
    localparam logic [1:0] KindTick  = 2'd2;

    // Register offsets, byte offset / 16
    localparam logic [5:0] IdxId        = 6'h02;
    localparam logic [5:0] IdxTpr       = 6'h08;
    localparam logic [5:0] IdxSvr       = 6'h0F;
    localparam logic [5:0] IdxIcrLow    = 6'h30;
    localparam logic [5:0] IdxIcrHigh   = 6'h31;
    localparam logic [5:0] IdxLvtTimer  = 6'h32;
    localparam logic [5:0] IdxLint0     = 6'h35;
    localparam logic [5:0] IdxLint1     = 6'h36;
    localparam logic [5:0] IdxLvtError  = 6'h37;
    localparam logic [5:0] IdxInitCount = 6'h38;
    localparam logic [5:0] IdxCurCount  = 6'h39;
    localparam logic [5:0] IdxDivide    = 6'h3E;

    // Writable bits of the masked registers (LVT timer, LINT0/1, LVT error, ICR low, divide)
    localparam logic [17:0] TimerKeep  = 18'h300FF;
    localparam logic [16:0] LintKeep   = 17'h1A7FF;
    localparam logic [16:0] ErrorKeep  = 17'h100FF;
    localparam logic [15:0] IcrKeep    = 16'hCFFF;
    localparam logic [3:0]  DivideKeep = 4'hB;

    localparam logic [8:0]  SvrReset   = 9'h0FF;
    localparam logic [17:0] TimerReset = 18'h10000;
    localparam logic [16:0] EntryReset = 17'h10000;

    localparam int unsigned SvrEnableBit   = 8;
    localparam int unsigned EntryMaskBit   = 16;
    localparam int unsigned TimerPeriodBit = 17;

    typedef struct packed {
        logic [31:0] write_data;
        logic [5:0]  reg_index;
        logic [1:0]  kind;
    } item_t;

    typedef struct packed {
        logic       ipi_trigger_level;
        logic       ipi_level_assert;
        logic [7:0] ipi_vector;
        logic [2:0] ipi_mode;
        logic [7:0] ipi_dest;
        logic       ipi_send;
        logic [7:0] irq_vector;
        logic       irq_fire;
        logic [31:0] read_data;
    } result_t;

    typedef struct packed {
        logic                  tick;
        logic                  load;
        logic [CountWidth-1:0] load_value;
        logic                  div_wr;
        logic [3:0]            div_value;
        logic                  periodic;
    } timer_ctrl_t;

    typedef struct packed {
        logic [CountWidth-1:0] init_count;
        logic [CountWidth-1:0] current_count;
        logic [3:0]            divide_code;
        logic                  expire;
    } timer_stat_t;

    // Prescaler divisor from the divide configuration: 2..128, or 1
    function automatic logic [7:0] divisor(input logic [3:0] code);
        logic [2:0] sel;
        logic [7:0] res;
        sel = {code[3], code[1:0]};
        if (sel == 3'd7)
        begin
            res = 8'd1;
        end
        else
        begin
            res = 8'd2 << sel;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/lapic_timer.sv
module lapic_timer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lapic_pkg::timer_ctrl_t ctrl,
    output lapic_pkg::timer_stat_t stat
);

    logic [lapic_pkg::CountWidth-1:0] init_reg, init_next;
    logic [lapic_pkg::CountWidth-1:0] cur_reg, cur_next;
    logic [lapic_pkg::CountWidth-1:0] cur_dec;
    logic [6:0] pre_reg, pre_next;
    logic [7:0] pre_inc;
    logic [3:0] div_reg, div_next;
    logic       expire;

    assign pre_inc = {1'b0, pre_reg} + 8'd1;
    assign cur_dec = cur_reg - {{(lapic_pkg::CountWidth-1){1'b0}}, 1'b1};

    always_comb
    begin
        init_next = init_reg;
        cur_next  = cur_reg;
        pre_next  = pre_reg;
        div_next  = div_reg;
        expire    = 1'b0;
        if (ctrl.load)
        begin
            init_next = ctrl.load_value;
            cur_next  = ctrl.load_value;
            pre_next  = '0;
        end
        if (ctrl.div_wr)
        begin
            div_next = ctrl.div_value;
        end
        if (ctrl.tick && cur_reg != '0)
        begin
            if (pre_inc >= lapic_pkg::divisor(div_reg))
            begin
                pre_next = '0;
                cur_next = cur_dec;
                if (cur_dec == '0)
                begin
                    expire = 1'b1;
                    if (ctrl.periodic)
                    begin
                        cur_next = init_reg;
                    end
                end
            end
            else
            begin
                pre_next = pre_inc[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            cur_reg  <= '0;
            pre_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            init_reg <= init_next;
            cur_reg  <= cur_next;
            pre_reg  <= pre_next;
            div_reg  <= div_next;
        end
    end

    assign stat.init_count    = init_reg;
    assign stat.current_count = cur_reg;
    assign stat.divide_code   = div_reg;
    assign stat.expire        = expire;

    // prescaler only runs while the count is live
    a_pre_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg == '0 |-> pre_reg == '0)
        else $error("prescaler nonzero with stopped count");

    a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == '0 && !ctrl.load) |=> cur_reg == '0)
        else $error("stopped timer restarted without a load");

    a_expire_tick: assert property (@(posedge clk) disable iff (!rst_n)
        expire |-> ctrl.tick && !ctrl.load)
        else $error("timer expiry outside a tick");

endmodule

>>> hw/rtl/lapic_regfile.sv
module lapic_regfile (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  lapic_pkg::item_t       item,
    input  logic [7:0]             local_id,
    input  lapic_pkg::timer_stat_t tstat,
    output lapic_pkg::timer_ctrl_t tctrl,
    output lapic_pkg::result_t     result
);

    logic [8:0]  svr_reg;
    logic [7:0]  tpr_reg;
    logic [17:0] timer_reg;
    logic [16:0] lint0_reg;
    logic [16:0] lint1_reg;
    logic [16:0] error_reg;
    logic [7:0]  icr_dest_reg;
    logic [15:0] icr_cmd_reg;
    logic [15:0] icr_cmd_new;
    logic        wr;
    logic [31:0] rd;

    assign wr          = step && item.kind == lapic_pkg::KindWrite;
    assign icr_cmd_new = item.write_data[15:0] & lapic_pkg::IcrKeep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svr_reg      <= lapic_pkg::SvrReset;
            tpr_reg      <= '0;
            timer_reg    <= lapic_pkg::TimerReset;
            lint0_reg    <= lapic_pkg::EntryReset;
            lint1_reg    <= lapic_pkg::EntryReset;
            error_reg    <= lapic_pkg::EntryReset;
            icr_dest_reg <= '0;
            icr_cmd_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (item.reg_index)
                lapic_pkg::IdxTpr:      tpr_reg      <= item.write_data[7:0];
                lapic_pkg::IdxSvr:      svr_reg      <= item.write_data[8:0];
                lapic_pkg::IdxIcrLow:   icr_cmd_reg  <= icr_cmd_new;
                lapic_pkg::IdxIcrHigh:  icr_dest_reg <= item.write_data[31:24];
                lapic_pkg::IdxLvtTimer:
                    timer_reg <= item.write_data[17:0] & lapic_pkg::TimerKeep;
                lapic_pkg::IdxLint0:
                    lint0_reg <= item.write_data[16:0] & lapic_pkg::LintKeep;
                lapic_pkg::IdxLint1:
                    lint1_reg <= item.write_data[16:0] & lapic_pkg::LintKeep;
                lapic_pkg::IdxLvtError:
                    error_reg <= item.write_data[16:0] & lapic_pkg::ErrorKeep;
                default: ;
            endcase
        end
    end

    // timer controls
    always_comb
    begin
        tctrl.tick       = step && item.kind == lapic_pkg::KindTick;
        tctrl.load       = wr && item.reg_index == lapic_pkg::IdxInitCount;
        tctrl.load_value = item.write_data[lapic_pkg::CountWidth-1:0];
        tctrl.div_wr     = wr && item.reg_index == lapic_pkg::IdxDivide;
        tctrl.div_value  = item.write_data[3:0] & lapic_pkg::DivideKeep;
        tctrl.periodic   = timer_reg[lapic_pkg::TimerPeriodBit];
    end

    // read mux
    always_comb
    begin
        unique case (item.reg_index)
            lapic_pkg::IdxId:        rd = {local_id, 24'd0};
            lapic_pkg::IdxTpr:       rd = 32'(tpr_reg);
            lapic_pkg::IdxSvr:       rd = 32'(svr_reg);
            lapic_pkg::IdxIcrLow:    rd = 32'(icr_cmd_reg);
            lapic_pkg::IdxIcrHigh:   rd = {icr_dest_reg, 24'd0};
            lapic_pkg::IdxLvtTimer:  rd = 32'(timer_reg);
            lapic_pkg::IdxLint0:     rd = 32'(lint0_reg);
            lapic_pkg::IdxLint1:     rd = 32'(lint1_reg);
            lapic_pkg::IdxLvtError:  rd = 32'(error_reg);
            lapic_pkg::IdxInitCount: rd = 32'(tstat.init_count);
            lapic_pkg::IdxCurCount:  rd = 32'(tstat.current_count);
            lapic_pkg::IdxDivide:    rd = 32'(tstat.divide_code);
            default:                 rd = '0;
        endcase
    end

    always_comb
    begin
        result = '0;
        if (item.kind == lapic_pkg::KindRead)
        begin
            result.read_data = rd;
        end
        if (tstat.expire && !timer_reg[lapic_pkg::EntryMaskBit] &&
            svr_reg[lapic_pkg::SvrEnableBit])
        begin
            result.irq_fire   = 1'b1;
            result.irq_vector = timer_reg[7:0];
        end
        if (item.kind == lapic_pkg::KindWrite && item.reg_index == lapic_pkg::IdxIcrLow)
        begin
            result.ipi_send          = 1'b1;
            result.ipi_dest          = icr_dest_reg;
            result.ipi_mode          = icr_cmd_new[10:8];
            result.ipi_vector        = icr_cmd_new[7:0];
            result.ipi_level_assert  = icr_cmd_new[14];
            result.ipi_trigger_level = icr_cmd_new[15];
        end
    end

endmodule

>>> hw/rtl/local_apic_timer_ipi_regs_top.sv
// Local interrupt controller slice: register file, IPI command and local timer.
// Items pass the input reg, then the result reg. One item per cycle while m_tready
// is high or the result reg is empty; state is updated as an item enters the result reg.
// Reset (rst_n, async, active low): registers to power-on values, timer stopped,
// both item registers empty.
module local_apic_timer_ipi_regs_top (
    input  logic        clk,
    input  logic        rst_n,
    // item input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [5:0] reg_index, [37:6] write_data, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] read_data, [32] irq_fire, [40:33] irq_vector, [41] ipi_send,
    // [49:42] ipi_dest, [52:50] ipi_mode, [60:53] ipi_vector,
    // [61] ipi_level_assert, [62] ipi_trigger_level, [63] zero
    output logic [63:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                   in_valid_reg, in_valid_next;
    lapic_pkg::item_t       in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    lapic_pkg::result_t     out_res_reg;
    lapic_pkg::result_t     result;
    lapic_pkg::timer_ctrl_t tctrl;
    lapic_pkg::timer_stat_t tstat;
    logic [7:0]             local_id_reg;
    logic                   s_accept;
    logic                   advance;
    logic                   step;

    // The result register frees up whenever it is empty or being drained, so
    // the input register moves on and a new item is taken in the same cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.kind       <= s_tuser;
            in_item_reg.reg_index  <= s_tdata[5:0];
            in_item_reg.write_data <= s_tdata[37:6];
        end
        if (step)
        begin
            out_res_reg <= result;
        end
    end

    // APB: one register, the identifier, at byte address 0
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == 3'd0)
        begin
            local_id_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr == 3'd0) ? 32'(local_id_reg) : '0;

    lapic_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_item_reg),
        .local_id (local_id_reg),
        .tstat    (tstat),
        .tctrl    (tctrl),
        .result   (result)
    );

    lapic_timer u_timer (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctrl),
        .stat  (tstat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    // a tick never issues an IPI, an ICR write never fires the timer
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.irq_fire && out_res_reg.ipi_send))
        else $error("timer interrupt and IPI in one result");

    // an item waiting in the input register moves on once the result reg frees
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item held although result register was free");

endmodule
